### hdl/aes_pkg.sv
// Shared types, constants and round functions for the AES-128 block cipher.
`timescale 1ns / 1ps

package aes_pkg;

	localparam logic [3:0] ROUNDS = 4'd10;

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;

	typedef struct packed {
		logic        mode;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes_out_t;

	typedef struct packed {
		logic       load;
		logic       kload;
		logic       kstep;
		logic       klast;
		logic       step;
		logic       out_write;
		logic [3:0] cnt;
	} aes_cmd_t;

	localparam logic [7:0] FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] DEC_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] getb(input logic [127:0] s, input int n);
		return s[127 - 8*n -: 8];
	endfunction

	function automatic logic [127:0] sub_fwd(input logic [127:0] s);
		logic [127:0] t;
		for (int n = 0; n < 16; n++) t[127 - 8*n -: 8] = FWD_SBOX[getb(s, n)];
		return t;
	endfunction

	function automatic logic [127:0] sub_inv(input logic [127:0] s);
		logic [127:0] t;
		for (int n = 0; n < 16; n++) t[127 - 8*n -: 8] = DEC_SBOX[getb(s, n)];
		return t;
	endfunction

	function automatic logic [127:0] rot_rows(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8*(4*c + r) -: 8] =
					getb(s, 4*(inv ? ((c + 4 - r) & 3) : ((c + r) & 3)) + r);
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, u, v, al;
		for (int c = 0; c < 4; c++) begin
			a0 = getb(s, 4*c);
			a1 = getb(s, 4*c + 1);
			a2 = getb(s, 4*c + 2);
			a3 = getb(s, 4*c + 3);
			if (inv) begin
				u = xtime(xtime(a0 ^ a2));
				v = xtime(xtime(a1 ^ a3));
				a0 = a0 ^ u;
				a1 = a1 ^ v;
				a2 = a2 ^ u;
				a3 = a3 ^ v;
			end
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 8*(4*c)     -: 8] = xtime(a0 ^ a1) ^ a0 ^ al;
			t[127 - 8*(4*c + 1) -: 8] = xtime(a1 ^ a2) ^ a1 ^ al;
			t[127 - 8*(4*c + 2) -: 8] = xtime(a2 ^ a3) ^ a2 ^ al;
			t[127 - 8*(4*c + 3) -: 8] = xtime(a3 ^ a0) ^ a3 ^ al;
		end
		return t;
	endfunction

	function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
		return {FWD_SBOX[w[23:16]] ^ rc, FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]],
			FWD_SBOX[w[31:24]]};
	endfunction

	// next round key from the current one
	function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] n0, n1, n2, n3;
		n0 = k[127:96] ^ sub_rot(k[31:0], rc);
		n1 = k[95:64] ^ n0;
		n2 = k[63:32] ^ n1;
		n3 = k[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// previous round key from the current one
	function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] p0, p1, p2, p3;
		p3 = k[31:0] ^ k[63:32];
		p2 = k[63:32] ^ k[95:64];
		p1 = k[95:64] ^ k[127:96];
		p0 = k[127:96] ^ sub_rot(p3, rc);
		return {p0, p1, p2, p3};
	endfunction

endpackage

### hdl/aes_ctrl.sv
// Sequencer for key expansion, cipher rounds and result hand-off.
`timescale 1ns / 1ps

module aes_ctrl import aes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     key_write,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output aes_cmd_t cmd
);

	localparam logic [1:0] S_KEY  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.cnt = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_KEY: begin
				cmd.kload = (cnt_q == 4'd0);
				cmd.kstep = (cnt_q != 4'd0);
				cmd.klast = (cnt_q == ROUNDS);
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == ROUNDS) begin
					state_d = S_IDLE;
					cnt_d   = 4'd0;
				end
			end
			S_IDLE: begin
				in_ready = !key_write;
				if (in_valid && !key_write) begin
					cmd.load = 1'b1;
					cnt_d    = 4'd1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == ROUNDS) begin
					state_d = S_DONE;
					cnt_d   = 4'd0;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_write = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_KEY;
		endcase
		if (key_write) begin
			state_d = S_KEY;
			cnt_d   = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_KEY;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_write) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/aes_dp.sv
// Key registers, round-key register and one-round-per-cycle cipher datapath.
`timescale 1ns / 1ps

module aes_dp import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  aes_in_t     in_data,
	input  aes_cmd_t    cmd,
	output aes_out_t    out_data
);

	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] state_q, rk_q, last_rk_q, result_q;
	logic         dec_q;
	logic [127:0] key, start_key, rk_n, st_n, tmp;
	logic [3:0]   rc_idx;
	logic [7:0]   rc;
	logic         do_inv;

	assign key       = {key_high_q, key_low_q};
	assign start_key = in_data.mode ? last_rk_q : key;
	assign do_inv    = cmd.step && dec_q;
	assign rc_idx    = do_inv ? (ROUNDS - cmd.cnt) : (cmd.cnt - 4'd1);
	assign rc        = rcon(rc_idx);
	assign rk_n      = do_inv ? key_inv(rk_q, rc) : key_fwd(rk_q, rc);

	always_comb begin
		if (dec_q) begin
			tmp  = sub_inv(rot_rows(state_q, 1'b1)) ^ rk_n;
			st_n = (cmd.cnt == ROUNDS) ? tmp : mix_columns(tmp, 1'b1);
		end else begin
			tmp  = rot_rows(sub_fwd(state_q), 1'b0);
			st_n = ((cmd.cnt == ROUNDS) ? tmp : mix_columns(tmp, 1'b0)) ^ rk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_HIGH) key_high_q <= cfg_data;
			if (cfg_index == REG_KEY_LOW)  key_low_q  <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= {in_data.block_high, in_data.block_low} ^ start_key;
			rk_q    <= start_key;
			dec_q   <= in_data.mode;
		end else if (cmd.step) begin
			state_q <= st_n;
			rk_q    <= rk_n;
		end else if (cmd.kload) begin
			rk_q <= key;
		end else if (cmd.kstep) begin
			rk_q <= rk_n;
		end
		if (cmd.kstep && cmd.klast) last_rk_q <= rk_n;
		if (cmd.out_write) result_q <= state_q;
	end

	assign out_data.result_high = result_q[127:64];
	assign out_data.result_low  = result_q[63:0];

endmodule

### hdl/aes128_block_cipher.sv
// Top level of the AES-128 encrypt/decrypt block.
`timescale 1ns / 1ps

// AES-128, one 128-bit block per transaction, mode 0 encrypts and 1 decrypts.
// The result register is loaded in the hand-off state, after the ten rounds have
// run on the single round unit, and in_ready returns in the cycle after, so a new
// block is not taken before the last result is loaded; while a result waits in
// the output register, the next block is held in the hand-off state. Round keys
// are made on the fly; the last round key, needed to start decryption, is
// re-derived after reset and after each key register write, which keeps
// in_ready low after reset, and from the write cycle on after a key write,
// until that derivation is done.

module aes128_block_cipher import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  aes_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output aes_out_t    out_data
);

	aes_cmd_t cmd;
	logic     key_write;

	assign key_write = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	aes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_write (key_write),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	aes_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready while a transaction is in flight");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.kload, cmd.kstep, cmd.step, cmd.out_write}))
		else $error("conflicting datapath commands");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_write))
		else $error("result shown without a write");
`endif

endmodule

### bench/aes128_block_cipher_test.sv
// Self-checking bench for the AES-128 block cipher: predicted blocks against DUT results.
`timescale 1ns / 1ps

module aes128_block_cipher_test;
	import aes_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	aes_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	aes_out_t    out_data;

	aes128_block_cipher DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	localparam int IDLE_LIMIT = 5000;

	logic [63:0]  key_hi_q, key_lo_q;
	logic [31:0]  sched [44];
	aes_out_t     blocks_due [$];
	int           errors = 0;
	int           idle_cycles = 0;
	int           hold_off = 0;
	int           rx_wait = 0;
	bit           rx_random = 1;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// --- predictor ---
	function automatic logic [7:0] gf2(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = gf2(a);
		end
		return r;
	endfunction

	function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
		logic [7:0] inv, p, x;
		// multiplicative inverse by b^254, then affine map
		inv = 8'h01;
		p = b;
		for (int e = 0; e < 8; e++) begin
			if (e != 0) inv = gmul(inv, p);
			p = gmul(p, p);
		end
		x = inv;
		return x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
			^ {x[3:0], x[7:4]} ^ 8'h63;
	endfunction

	logic [7:0] fwd_tab [256];
	logic [7:0] inv_tab [256];

	task automatic build_boxes();
		for (int i = 0; i < 256; i++) begin
			fwd_tab[i] = sbox_fwd(i[7:0]);
			inv_tab[fwd_tab[i]] = i[7:0];
		end
	endtask

	task automatic expand_schedule();
		logic [31:0] t;
		logic [7:0]  rc;
		sched[0] = key_hi_q[63:32];
		sched[1] = key_hi_q[31:0];
		sched[2] = key_lo_q[63:32];
		sched[3] = key_lo_q[31:0];
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			t = sched[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_tab[t[31:24]] ^ rc, fwd_tab[t[23:16]], fwd_tab[t[15:8]],
					fwd_tab[t[7:0]]};
				rc = gf2(rc);
			end
			sched[i] = sched[i-4] ^ t;
		end
	endtask

	typedef logic [7:0] state_t [16];

	function automatic void add_key(ref state_t s, input int r);
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				s[4*c+k] ^= sched[4*r+c][31-8*k -: 8];
	endfunction

	function automatic void subst(ref state_t s, input bit inv);
		for (int i = 0; i < 16; i++) s[i] = inv ? inv_tab[s[i]] : fwd_tab[s[i]];
	endfunction

	function automatic void rotate(ref state_t s, input bit inv);
		state_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[4*c+r] = s[4*((inv ? (c + 4 - r) : (c + r)) & 3) + r];
		s = t;
	endfunction

	function automatic void mix(ref state_t s, input bit inv);
		logic [7:0] a0, a1, a2, a3, u, v, al;
		for (int c = 0; c < 4; c++) begin
			a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
			if (inv) begin
				u = gf2(gf2(a0 ^ a2));
				v = gf2(gf2(a1 ^ a3));
				a0 ^= u; a1 ^= v; a2 ^= u; a3 ^= v;
			end
			al = a0 ^ a1 ^ a2 ^ a3;
			s[4*c]   = gf2(a0 ^ a1) ^ a0 ^ al;
			s[4*c+1] = gf2(a1 ^ a2) ^ a1 ^ al;
			s[4*c+2] = gf2(a2 ^ a3) ^ a2 ^ al;
			s[4*c+3] = gf2(a3 ^ a0) ^ a3 ^ al;
		end
	endfunction

	function automatic aes_out_t cipher_block(input aes_in_t it);
		state_t   s;
		aes_out_t o;
		for (int i = 0; i < 8; i++) begin
			s[i]   = it.block_high[63-8*i -: 8];
			s[8+i] = it.block_low[63-8*i -: 8];
		end
		if (!it.mode) begin
			add_key(s, 0);
			for (int r = 1; r < ROUNDS; r++) begin
				subst(s, 0); rotate(s, 0); mix(s, 0); add_key(s, r);
			end
			subst(s, 0); rotate(s, 0); add_key(s, ROUNDS);
		end else begin
			add_key(s, ROUNDS); rotate(s, 1); subst(s, 1);
			for (int r = ROUNDS - 1; r >= 1; r--) begin
				add_key(s, r); mix(s, 1); rotate(s, 1); subst(s, 1);
			end
			add_key(s, 0);
		end
		for (int i = 0; i < 8; i++) begin
			o.result_high[63-8*i -: 8] = s[i];
			o.result_low[63-8*i -: 8]  = s[8+i];
		end
		return o;
	endfunction

	// --- checking ---
	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		aes_out_t want;
		if (out_valid && out_ready) begin
			if (blocks_due.size() == 0) begin
				report("unexpected transaction", out_data.result_high, 64'h0);
			end else begin
				want = blocks_due.pop_front();
				if (out_data.result_high !== want.result_high)
					report("result_high", out_data.result_high, want.result_high);
				if (out_data.result_low !== want.result_low)
					report("result_low", out_data.result_low, want.result_low);
			end
		end
	end

	// receiver back-pressure: a fresh wait is drawn after every transaction, unless a hold-off is running
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else if (hold_off > 0) begin
			hold_off--;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			rx_wait = rx_random ? $urandom_range(0, 7) : 0;
			out_ready <= (rx_wait == 0);
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= (rx_wait == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("aes128_block_cipher_test: done, errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// --- stimulus ---
	bit tx_random = 1;

	// in_valid is left high after acceptance; drain() or a next call that draws a gap lowers it
	task automatic send_block(input logic m, input logic [63:0] hi, input logic [63:0] lo);
		aes_in_t it;
		int gap;
		gap = tx_random ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.mode = m;
		it.block_high = hi;
		it.block_low = lo;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		blocks_due.insert(blocks_due.size(), cipher_block(it));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (blocks_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_HIGH) key_hi_q = val;
		else if (idx == REG_KEY_LOW) key_lo_q = val;
		expand_schedule();
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_zero_key();
		send_block(0, 64'h0, 64'h0);
		send_block(1, 64'h0, 64'h0);
		send_block(0, '1, '1);
		send_block(1, '1, '1);
		drain();
	endtask

	task automatic test_known_vector();
		write_key(REG_KEY_HIGH, 64'h0001020304050607);
		write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_block(0, 64'h8000000000000000, 64'h0000000000000001);
		send_block(1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		drain();
	endtask

	task automatic test_key_extremes();
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		send_block(0, 64'h0, '1);
		send_block(1, '1, 64'h0);
		drain();
		// index outside the register map is ignored
		write_key(2'd2, rand64());
		write_key(2'd3, rand64());
		send_block(0, 64'h0123456789abcdef, 64'hfedcba9876543210);
		drain();
		write_key(REG_KEY_HIGH, 64'h0);
		send_block(1, 64'h0, 64'h0);
		drain();
	endtask

	task automatic test_back_pressure();
		hold_off = 300;
		for (int i = 0; i < 12; i++) send_block($urandom_range(0, 1), rand64(), rand64());
		drain();
	endtask

	task automatic test_streaming();
		tx_random = 0;
		rx_random = 0;
		for (int i = 0; i < 40; i++) send_block($urandom_range(0, 1), rand64(), rand64());
		drain();
		tx_random = 1;
		rx_random = 1;
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			write_key(REG_KEY_HIGH, rand64());
			write_key(REG_KEY_LOW, rand64());
			for (int i = 0; i < 90; i++)
				send_block($urandom_range(0, 1), rand64(), rand64());
			drain();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		key_hi_q  = '0;
		key_lo_q  = '0;
		build_boxes();
		expand_schedule();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_key();
		test_known_vector();
		test_key_extremes();
		test_back_pressure();
		test_streaming();
		test_random();
		if (errors == 0 && blocks_due.size() == 0)
			$display("aes128_block_cipher_test: done, clean");
		else
			$display("aes128_block_cipher_test: done, errors");
		$finish;
	end

endmodule
